@@ src/csrt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csrt_pkg: shared types and codes for the CSR graph transpose block
// Word layouts for both channels, function and status codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package csrt_pkg;

  // Fixed field widths
  localparam int NODE_W   = 10;
  localparam int IDX_W    = 12;
  localparam int VALUE_W  = 13;
  localparam int STATUS_W = 2;
  localparam int FUNC_W   = 2;
  localparam int CFG_W    = 11;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_BUILD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_OFF = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_DST = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;     // latch the input word
    logic clear_step;  // zero one count entry after reset
    logic load_exec;   // check and store an edge, fetch its count
    logic load_inc;    // write back the incremented count
    logic read_exec;   // check and issue an offset or destination read
    logic bld_init;    // start a build: offset zero, counters cleared
    logic sum_step;    // prefix-sum pipeline step
    logic edge_rd;     // fetch one stored edge
    logic cur_rd;      // fetch the fill cursor of the edge's destination
    logic scatter_wr;  // place the source and bump the cursor
    logic bld_done;    // commit the build totals
    logic push;        // move the result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [FUNC_W-1:0] in_func;
    logic clear_last;
    logic load_ok;
    logic sum_last;
    logic edge_none;
    logic edge_last;
    logic edge_skip;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ src/csrt_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csrt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module csrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/csrt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csrt_ctrl: sequencing state machine for the CSR graph transpose
// Runs the count clear after reset, one input word at a time, and the
// build sequence (prefix sum, then stable scatter of the stored edges).
// ----------------------------------------------------------------------------
module csrt_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csrt_pkg::ctrl_sts_t  sts,
  output csrt_pkg::ctrl_cmd_t  cmd
);
  import csrt_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR    = 13'b0_0000_0000_0001,
    S_IDLE     = 13'b0_0000_0000_0010,
    S_LOAD     = 13'b0_0000_0000_0100,
    S_LOAD_INC = 13'b0_0000_0000_1000,
    S_READ     = 13'b0_0000_0001_0000,
    S_BLD_INIT = 13'b0_0000_0010_0000,
    S_BLD_SUM  = 13'b0_0000_0100_0000,
    S_BLD_ERD  = 13'b0_0000_1000_0000,
    S_BLD_CRD  = 13'b0_0001_0000_0000,
    S_BLD_WR   = 13'b0_0010_0000_0000,
    S_BLD_DONE = 13'b0_0100_0000_0000,
    S_FINISH   = 13'b0_1000_0000_0000,
    S_SPARE    = 13'b1_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (sts.in_func)
            FUNC_LOAD:  state_next = S_LOAD;
            FUNC_BUILD: state_next = S_BLD_INIT;
            default:    state_next = S_READ;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_exec = 1'b1;
        state_next = sts.load_ok ? S_LOAD_INC : S_FINISH;
      end
      S_LOAD_INC: begin
        cmd.load_inc = 1'b1;
        state_next = S_FINISH;
      end
      S_READ: begin
        cmd.read_exec = 1'b1;
        state_next = S_FINISH;
      end
      S_BLD_INIT: begin
        cmd.bld_init = 1'b1;
        state_next = S_BLD_SUM;
      end
      S_BLD_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_next = sts.edge_none ? S_BLD_DONE : S_BLD_ERD;
        end
      end
      S_BLD_ERD: begin
        cmd.edge_rd = 1'b1;
        state_next = S_BLD_CRD;
      end
      S_BLD_CRD: begin
        cmd.cur_rd = 1'b1;
        if (!sts.edge_skip) begin
          state_next = S_BLD_WR;
        end else begin
          state_next = sts.edge_last ? S_BLD_DONE : S_BLD_ERD;
        end
      end
      S_BLD_WR: begin
        cmd.scatter_wr = 1'b1;
        state_next = sts.edge_last ? S_BLD_DONE : S_BLD_ERD;
      end
      S_BLD_DONE: begin
        cmd.bld_done = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ src/csrt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csrt_datapath: storage and arithmetic for the CSR graph transpose
// Holds the in-degree counts, fill cursors, reverse offsets, the edge store
// and the reverse destinations, plus the totals and the output register.
// ----------------------------------------------------------------------------
module csrt_datapath #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  csrt_pkg::ctrl_cmd_t             cmd,
  output csrt_pkg::ctrl_sts_t             sts,
  input  csrt_pkg::in_item_t              in_data,
  input  logic                            cfg_valid,
  input  logic [csrt_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output csrt_pkg::out_item_t             out_data
);
  import csrt_pkg::*;

  localparam int NW  = $clog2(MAX_NODES + 1);  // node count, offset address
  localparam int NAW = $clog2(MAX_NODES);      // node address
  localparam int EW  = $clog2(MAX_EDGES + 1);  // edge count, offset value
  localparam int EAW = $clog2(MAX_EDGES);      // edge address

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_DST  = 2'd2;

  // Registers
  logic [CFG_W-1:0]    node_count;
  in_item_t            item;
  logic [EW-1:0]       edge_total;
  logic [EW-1:0]       built_total;
  logic                built_flag;
  logic [NW-1:0]       node_ctr;
  logic                sum_vld;
  logic [NAW-1:0]      sum_idx;
  logic [EW-1:0]       sum;
  logic [EW-1:0]       e_ctr;
  logic [STATUS_W-1:0] res_status;
  logic [1:0]          res_kind;

  // RAM ports
  logic           deg_we, deg_re;
  logic [NAW-1:0] deg_waddr, deg_raddr;
  logic [EW-1:0]  deg_wdata, deg_rdata;
  logic           cur_we, cur_re;
  logic [NAW-1:0] cur_waddr, cur_raddr;
  logic [EW-1:0]  cur_wdata, cur_rdata;
  logic           off_we, off_re;
  logic [NW-1:0]  off_waddr, off_raddr;
  logic [EW-1:0]  off_wdata, off_rdata;
  logic           edge_we, edge_re;
  logic [EAW-1:0] edge_waddr, edge_raddr;
  logic [NODE_W-1:0] esrc_rdata, edst_rdata;
  logic           rdst_we, rdst_re;
  logic [EAW-1:0] rdst_waddr, rdst_raddr;
  logic [NODE_W-1:0] rdst_wdata, rdst_rdata;

  // Decodes
  logic [NW-1:0]      eff_nodes;
  logic               load_bad, load_full, load_ok;
  logic               read_is_dst, off_bad, dst_bad, read_bad;
  logic               sum_issue;
  logic [EW-1:0]      sum_add, sum_new;
  logic               edge_skip, edge_last;
  logic               out_free;
  logic [VALUE_W-1:0] res_value;

  // Effective node count: node_count capped at MAX_NODES
  assign eff_nodes = (32'(node_count) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(node_count);

  // Load checks: range fault first, then full store
  assign load_bad  = (32'(item.src_node) >= 32'(eff_nodes)) ||
                     (32'(item.dst_node) >= 32'(eff_nodes));
  assign load_full = 32'(edge_total) >= 32'(MAX_EDGES);
  assign load_ok   = !load_bad && !load_full;

  // Read checks
  assign read_is_dst = (item.func == FUNC_RD_DST);
  assign off_bad     = !built_flag || (32'(item.read_index) > 32'(eff_nodes)) ||
                       (32'(item.read_index) > 32'(MAX_NODES));
  assign dst_bad     = !built_flag || (32'(item.read_index) >= 32'(built_total)) ||
                       (32'(item.read_index) >= 32'(MAX_EDGES));
  assign read_bad    = read_is_dst ? dst_bad : off_bad;

  // Prefix sum: issue one count read a cycle, accumulate in the cycle after
  assign sum_issue = cmd.sum_step && (node_ctr != NW'(MAX_NODES));
  assign sum_add   = (32'(sum_idx) < 32'(eff_nodes)) ? deg_rdata : '0;
  assign sum_new   = sum + sum_add;

  // Scatter: skip edges whose destination is out of range
  assign edge_skip = 32'(edst_rdata) >= 32'(eff_nodes);
  assign edge_last = (32'(e_ctr) + 32'd1) == 32'(edge_total);

  assign out_free = !out_valid || out_ready;

  // Count memory port select
  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = NAW'(node_ctr);
    deg_wdata = '0;
    deg_re    = 1'b0;
    deg_raddr = NAW'(item.dst_node);
    if (cmd.clear_step) begin
      deg_we = 1'b1;
    end
    if (cmd.load_exec && load_ok) begin
      deg_re = 1'b1;
    end
    if (cmd.load_inc) begin
      deg_we    = 1'b1;
      deg_waddr = NAW'(item.dst_node);
      deg_wdata = deg_rdata + EW'(1);
    end
    if (sum_issue) begin
      deg_re    = 1'b1;
      deg_raddr = NAW'(node_ctr);
    end
    // Clear each count once it has been summed
    if (sum_vld) begin
      deg_we    = 1'b1;
      deg_waddr = sum_idx;
      deg_wdata = '0;
    end
  end

  // Cursor memory port select: seeded with offsets, bumped on scatter
  always_comb begin
    cur_we    = sum_vld;
    cur_waddr = sum_idx;
    cur_wdata = sum;
    cur_re    = cmd.cur_rd && !edge_skip;
    cur_raddr = NAW'(edst_rdata);
    if (cmd.scatter_wr) begin
      cur_we    = 1'b1;
      cur_waddr = NAW'(edst_rdata);
      cur_wdata = cur_rdata + EW'(1);
    end
  end

  // Offset memory port select
  always_comb begin
    off_we    = sum_vld;
    off_waddr = NW'(sum_idx) + NW'(1);
    off_wdata = sum_new;
    if (cmd.bld_init) begin
      off_we    = 1'b1;
      off_waddr = '0;
      off_wdata = '0;
    end
    off_re    = cmd.read_exec && !read_bad && !read_is_dst;
    off_raddr = NW'(item.read_index);
  end

  // Edge store and reverse destination port select
  assign edge_we    = cmd.load_exec && load_ok;
  assign edge_waddr = EAW'(edge_total);
  assign edge_re    = cmd.edge_rd;
  assign edge_raddr = EAW'(e_ctr);
  assign rdst_we    = cmd.scatter_wr && (32'(cur_rdata) < 32'(MAX_EDGES));
  assign rdst_waddr = EAW'(cur_rdata);
  assign rdst_wdata = esrc_rdata;
  assign rdst_re    = cmd.read_exec && !read_bad && read_is_dst;
  assign rdst_raddr = EAW'(item.read_index);

  csrt_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_deg_ram (
    .clk(clk), .wr_en(deg_we), .wr_addr(deg_waddr), .wr_data(deg_wdata),
    .rd_en(deg_re), .rd_addr(deg_raddr), .rd_data(deg_rdata)
  );

  csrt_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_cur_ram (
    .clk(clk), .wr_en(cur_we), .wr_addr(cur_waddr), .wr_data(cur_wdata),
    .rd_en(cur_re), .rd_addr(cur_raddr), .rd_data(cur_rdata)
  );

  csrt_ram #(.WIDTH(EW), .DEPTH(MAX_NODES + 1)) u_off_ram (
    .clk(clk), .wr_en(off_we), .wr_addr(off_waddr), .wr_data(off_wdata),
    .rd_en(off_re), .rd_addr(off_raddr), .rd_data(off_rdata)
  );

  csrt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_esrc_ram (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(item.src_node),
    .rd_en(edge_re), .rd_addr(edge_raddr), .rd_data(esrc_rdata)
  );

  csrt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_edst_ram (
    .clk(clk), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(item.dst_node),
    .rd_en(edge_re), .rd_addr(edge_raddr), .rd_data(edst_rdata)
  );

  csrt_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_rdst_ram (
    .clk(clk), .wr_en(rdst_we), .wr_addr(rdst_waddr), .wr_data(rdst_wdata),
    .rd_en(rdst_re), .rd_addr(rdst_raddr), .rd_data(rdst_rdata)
  );

  // Control registers, counters and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_COUNT_RST;
      edge_total  <= '0;
      built_total <= '0;
      built_flag  <= 1'b0;
      node_ctr    <= '0;
      sum_vld     <= 1'b0;
      e_ctr       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (cmd.clear_step || sum_issue) begin
        node_ctr <= node_ctr + NW'(1);
      end
      if (cmd.bld_init) begin
        node_ctr <= '0;
        e_ctr    <= '0;
      end
      sum_vld <= sum_issue;
      if (cmd.load_exec && load_ok) begin
        edge_total <= edge_total + EW'(1);
      end
      if ((cmd.cur_rd && edge_skip) || cmd.scatter_wr) begin
        e_ctr <= e_ctr + EW'(1);
      end
      if (cmd.bld_done) begin
        built_total <= sum;
        built_flag  <= 1'b1;
        edge_total  <= '0;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result value select
  always_comb begin
    res_value = '0;
    if (res_status == ST_OK) begin
      case (res_kind)
        KIND_OFF: res_value = VALUE_W'(off_rdata);
        KIND_DST: res_value = VALUE_W'(rdst_rdata);
        default:  res_value = '0;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    sum_idx <= NAW'(node_ctr);
    if (cmd.bld_init) begin
      sum <= '0;
    end else if (sum_vld) begin
      sum <= sum_new;
    end
    if (cmd.load_exec) begin
      res_status <= load_bad ? ST_RANGE : (load_full ? ST_FULL : ST_OK);
      res_kind   <= KIND_NONE;
    end
    if (cmd.read_exec) begin
      res_status <= read_bad ? ST_BAD : ST_OK;
      res_kind   <= read_is_dst ? KIND_DST : KIND_OFF;
    end
    if (cmd.bld_done) begin
      res_status <= ST_OK;
      res_kind   <= KIND_NONE;
    end
    if (cmd.push) begin
      out_data.read_value <= res_value;
      out_data.status     <= res_status;
    end
  end

  // Status to the controller
  always_comb begin
    sts            = '0;
    sts.in_func    = in_data.func;
    sts.clear_last = (node_ctr == NW'(MAX_NODES - 1));
    sts.load_ok    = load_ok;
    sts.sum_last   = sum_vld && (sum_idx == NAW'(MAX_NODES - 1));
    sts.edge_none  = (edge_total == '0);
    sts.edge_last  = edge_last;
    sts.edge_skip  = edge_skip;
    sts.out_free   = out_free;
  end

  // A result never overwrites one still waiting
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || out_ready))
    else $error("result pushed over a pending word");

  // A stored edge bumps the edge total by one
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_exec && load_ok) |=> (edge_total == $past(edge_total) + EW'(1)))
    else $error("edge total did not advance on a stored edge");

  // Scatter positions stay below the reverse edge total
  a_scatter_pos: assert property (@(posedge clk) disable iff (rst)
    cmd.scatter_wr |-> (32'(cur_rdata) < 32'(sum)))
    else $error("scatter position beyond reverse edge total");

  // A finished build is marked and empties the edge store
  a_build_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.bld_done |=> (built_flag && (edge_total == '0)))
    else $error("build did not commit");

endmodule
`default_nettype wire

@@ src/csr_graph_transpose.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csr_graph_transpose: reverse adjacency (CSR transpose) builder
// Loads edges, counts in-degrees, builds reverse offsets by prefix sum and
// scatters sources stably into reverse destinations; reads return results.
//
//   channel  | signals                          | word
//   ---------+----------------------------------+------------------------
//   input    | in_valid, in_ready, in_data      | func, nodes, read index
//   output   | out_valid, out_ready, out_data   | read_value, status
//   config   | cfg_valid, cfg_ready, cfg_data   | node_count
//
// Steps: a stored load reads its in-degree count, then writes it back
// incremented, through the count memory's single read port; a build sums
// all MAX_NODES counts, then reads each stored edge, fetches its cursor and places it.
// Reset: a clearing pass zeroes the in-degree counts, with in_ready low;
// config writes are taken throughout.
// Stalls: a result waits in the output register while the next word is
// taken; the following result waits until that register is free.
// ----------------------------------------------------------------------------
module csr_graph_transpose #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  csrt_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output csrt_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [csrt_pkg::CFG_W-1:0] cfg_data
);
  import csrt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The register accepts a write in any cycle
  assign cfg_ready = 1'b1;

  csrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  csrt_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
